@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl of the phase difference demodulator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked at every clock edge outside of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/fpd_pkg.sv @@
// types, constants and the arctangent table of the phase difference demodulator
package fpd_pkg;

	localparam int NORM_W   = 60;  // normalized magnitude, msb set at bit 59
	localparam int CORDIC_W = 63;  // signed x/y datapath, leaves room for the cordic gain
	localparam int ATAN_W   = 40;  // table entries in units of 2^-40 rad
	localparam int ANGLE_W  = 42;  // signed angle accumulator
	localparam int THETA_W  = 41;  // clamped angle in [0, pi/2]
	localparam int MAG_W    = 42;  // angle in [0, pi]
	localparam int STEPS    = 40;
	localparam int STEP_W   = 6;
	localparam int OUT_W    = 24;
	localparam int SCALE_W  = 22;
	localparam int CHUNK_W  = 21;  // angle is scaled in two halves of this width
	localparam int HI_SHIFT = 19;  // 40 - CHUNK_W
	localparam int SUM_W    = 44;

	localparam logic [THETA_W-1:0] HALF_PI_Q40 = 41'd1727108826179;
	localparam logic [MAG_W-1:0]   PI_Q40      = 42'd3454217652358;
	localparam logic [SCALE_W-1:0] DEV_SCALE   = 22'd2670000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_START,
		ST_CORDIC,
		ST_SCALE_LO,
		ST_SCALE_HI,
		ST_SCALE_SUM
	} seq_state_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_NORM,
		C_ROT,
		C_CLAMP
	} cordic_state_t;

	typedef struct packed {
		logic start;
	} cordic_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_stat_t;

	// atan(2^-k) rounded to nearest at 2^-40; from k = 14 on it equals 2^(40-k)
	function automatic logic [ATAN_W-1:0] atan_q40(input logic [STEP_W-1:0] k);
		logic [ATAN_W:0] one;
		one = {1'b1, {ATAN_W{1'b0}}};
		case (k)
			6'd0:    atan_q40 = 40'd863554413089;
			6'd1:    atan_q40 = 40'd509785937287;
			6'd2:    atan_q40 = 40'd269356888665;
			6'd3:    atan_q40 = 40'd136729762476;
			6'd4:    atan_q40 = 40'd68630207382;
			6'd5:    atan_q40 = 40'd34348560106;
			6'd6:    atan_q40 = 40'd17178471287;
			6'd7:    atan_q40 = 40'd8589759836;
			6'd8:    atan_q40 = 40'd4294945451;
			6'd9:    atan_q40 = 40'd2147480917;
			6'd10:   atan_q40 = 40'd1073741483;
			6'd11:   atan_q40 = 40'd536870869;
			6'd12:   atan_q40 = 40'd268435451;
			6'd13:   atan_q40 = 40'd134217727;
			default: atan_q40 = ATAN_W'(one >> k);
		endcase
	endfunction

endpackage

@@ rtl/fpd_in_if.sv @@
// sample channel: valid/ready beat carrying one complex baseband sample
interface fpd_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_i;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	modport source (output valid, output sample_i, output sample_q, input ready);
	modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

@@ rtl/fpd_out_if.sv @@
// result channel: valid/ready beat carrying one frequency deviation word
interface fpd_out_if import fpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] freq_dev;

	modport source (output valid, output freq_dev, input ready);
	modport sink   (input valid, input freq_dev, output ready);
endinterface

@@ rtl/fpd_mul.sv @@
// shared registered signed multiplier
module fpd_mul #(
	parameter int OP_W = 25
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [OP_W-1:0]   a,
	input  logic signed [OP_W-1:0]   b,
	output logic signed [2*OP_W-1:0] prod
);

	logic signed [2*OP_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

@@ rtl/fpd_cordic.sv @@
// iterative vectoring cordic: normalize, rotate one step a cycle, clamp the angle
module fpd_cordic import fpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cordic_ctl_t        ctl,
	input  logic [NORM_W-1:0]  a,
	input  logic [NORM_W-1:0]  b,
	output cordic_stat_t       stat,
	output logic [THETA_W-1:0] theta
);

`include "assert_macros.svh"

	cordic_state_t               state_q, state_d;
	logic signed [CORDIC_W-1:0]  x_q, y_q;
	logic signed [ANGLE_W-1:0]   z_q;
	logic [STEP_W-1:0]           k_q;

	logic signed [CORDIC_W-1:0]  larger;
	logic                        need8, need1;
	logic signed [CORDIC_W-1:0]  dx, dy;
	logic signed [ANGLE_W-1:0]   rom_ext;

	assign larger  = (x_q > y_q) ? x_q : y_q;
	assign need8   = (larger[CORDIC_W-1:NORM_W-9] == '0);
	assign need1   = (larger[CORDIC_W-1:NORM_W-1] == '0);
	assign dx      = y_q >>> k_q;
	assign dy      = x_q >>> k_q;
	assign rom_ext = $signed({{(ANGLE_W-ATAN_W){1'b0}}, atan_q40(k_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		stat.busy = (state_q != C_IDLE);
		stat.done = 1'b0;
		case (state_q)
			C_IDLE: begin
				if (ctl.start) state_d = C_NORM;
			end
			C_NORM: begin
				if (!need1) state_d = C_ROT;
			end
			C_ROT: begin
				if (k_q == STEP_W'(STEPS - 1)) state_d = C_CLAMP;
			end
			C_CLAMP: begin
				stat.done = 1'b1;
				state_d   = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				x_q <= $signed({{(CORDIC_W-NORM_W){1'b0}}, a});
				y_q <= $signed({{(CORDIC_W-NORM_W){1'b0}}, b});
				z_q <= '0;
				k_q <= '0;
			end
			C_NORM: begin
				// coarse shift while far below bit 59, then single bits
				if (need8) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (need1) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			C_ROT: begin
				if (!y_q[CORDIC_W-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + rom_ext;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - rom_ext;
				end
				k_q <= k_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	// clamp to [0, pi/2]
	always_comb begin
		if (z_q[ANGLE_W-1]) begin
			theta = '0;
		end else if (z_q > $signed({1'b0, HALF_PI_Q40})) begin
			theta = HALF_PI_Q40;
		end else begin
			theta = z_q[THETA_W-1:0];
		end
	end

	`ASSERT_CLK(a_start_when_idle, clk, arst_n, ctl.start |-> !stat.busy, "cordic start while busy")
	`ASSERT_CLK(a_norm_msb, clk, arst_n, (state_q == C_ROT && k_q == '0) |-> (x_q[NORM_W-1] || y_q[NORM_W-1]), "rotation began on an unnormalized vector")
	`ASSERT_CLK(a_x_positive, clk, arst_n, (state_q == C_ROT) |-> !x_q[CORDIC_W-1], "cordic x overflowed")
	`ASSERT_CLK(a_done_pulse, clk, arst_n, stat.done |=> !stat.done, "cordic done held for more than a cycle")

endmodule

@@ rtl/fm_phase_difference_demod.sv @@
// fm polar discriminator: phase step between successive iq samples, scaled to a deviation
// steps from sample beat to result register: multiply, start, normalize, cordic rotations, clamp, scale;
//   normalize, rotations and clamp are skipped when the product's real part is zero
// a beat is taken only in idle, so a new sample waits until the sequencer is through with the last one
// a result still unclaimed in the output register holds the sequencer in its last scale step
// reset (arst_n low, async): sequencer idle, output empty, stored previous sample cleared to zero
module fm_phase_difference_demod import fpd_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	fpd_in_if.sink       samples,
	fpd_out_if.source    result
);

`include "assert_macros.svh"

	// conjugate product width and shared multiplier operand width
	localparam int CP_W  = 2 * SAMPLE_BITS + 1;
	localparam int MUL_W = (SAMPLE_BITS + 1 > SCALE_W + 1) ? SAMPLE_BITS + 1 : SCALE_W + 1;

	seq_state_t                    state_q, state_d;

	// current and previous sample
	logic signed [SAMPLE_BITS-1:0] n_i_q, n_q_q;
	logic signed [SAMPLE_BITS-1:0] p_i_q, p_q_q;

	// conjugate product, real and imaginary
	logic signed [CP_W-1:0]        re_q, im_q;
	logic [CP_W-1:0]               re_abs, im_abs;

	logic [MAG_W-1:0]              mag_q;
	logic                          neg_q;
	logic [SCALE_W-1:0]            acc_q;
	logic [SUM_W-1:0]              sum;
	logic [OUT_W-1:0]              dev_mag;

	// shared multiplier
	logic                          mul_en;
	logic signed [MUL_W-1:0]       mul_a, mul_b;
	logic signed [2*MUL_W-1:0]     prod;
	logic signed [CP_W-1:0]        prod_cp;

	// cordic handshake
	cordic_ctl_t                   cctl;
	cordic_stat_t                  cst;
	logic [THETA_W-1:0]            theta;

	// output register
	logic                          out_valid_q;
	logic signed [OUT_W-1:0]       freq_q;
	logic                          load;

	fpd_mul #(
		.OP_W (MUL_W)
	) u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	fpd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.a      ({{(NORM_W-CP_W){1'b0}}, re_abs}),
		.b      ({{(NORM_W-CP_W){1'b0}}, im_abs}),
		.stat   (cst),
		.theta  (theta)
	);

	assign prod_cp = $signed(prod[CP_W-1:0]);
	// magnitudes never reach 2^(CP_W-1), so the negation cannot wrap
	assign re_abs  = re_q[CP_W-1] ? CP_W'(-re_q) : CP_W'(re_q);
	assign im_abs  = im_q[CP_W-1] ? CP_W'(-im_q) : CP_W'(im_q);

	// scaled angle: floor((hi*S + floor(lo*S / 2^21)) / 2^19)
	assign sum     = SUM_W'(acc_q) + prod[SUM_W-1:0];
	assign dev_mag = sum[HI_SHIFT+OUT_W-1:HI_SHIFT];

	assign samples.ready   = (state_q == ST_IDLE);
	assign result.valid    = out_valid_q;
	assign result.freq_dev = freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			p_i_q       <= '0;
			p_q_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			// new sample becomes the stored one once all four products are taken
			if (state_q == ST_M4) begin
				p_i_q <= n_i_q;
				p_q_q <= n_q_q;
			end
		end
	end

	// sequencer: multiply, angle, scale, hand to the output register
	always_comb begin
		state_d    = state_q;
		mul_en     = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		cctl.start = 1'b0;
		load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (samples.valid) state_d = ST_M0;
			end
			ST_M0: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(n_i_q);
				mul_b   = MUL_W'(p_i_q);
				state_d = ST_M1;
			end
			ST_M1: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(n_q_q);
				mul_b   = MUL_W'(p_q_q);
				state_d = ST_M2;
			end
			ST_M2: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(n_q_q);
				mul_b   = MUL_W'(p_i_q);
				state_d = ST_M3;
			end
			ST_M3: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(n_i_q);
				mul_b   = MUL_W'(p_q_q);
				state_d = ST_M4;
			end
			ST_M4: begin
				state_d = ST_START;
			end
			ST_START: begin
				// zero real part goes straight to pi/2, no cordic
				if (re_q != '0) begin
					cctl.start = 1'b1;
					state_d    = ST_CORDIC;
				end else begin
					state_d = ST_SCALE_LO;
				end
			end
			ST_CORDIC: begin
				if (cst.done) state_d = ST_SCALE_LO;
			end
			ST_SCALE_LO: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'($signed({1'b0, mag_q[CHUNK_W-1:0]}));
				mul_b   = MUL_W'($signed({1'b0, DEV_SCALE}));
				state_d = ST_SCALE_HI;
			end
			ST_SCALE_HI: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'($signed({1'b0, mag_q[MAG_W-1:CHUNK_W]}));
				mul_b   = MUL_W'($signed({1'b0, DEV_SCALE}));
				state_d = ST_SCALE_SUM;
			end
			ST_SCALE_SUM: begin
				// wait here while an earlier result is still unclaimed
				load = !out_valid_q || result.ready;
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			n_i_q <= samples.sample_i;
			n_q_q <= samples.sample_q;
		end
		case (state_q)
			ST_M1: re_q <= prod_cp;
			ST_M2: re_q <= re_q + prod_cp;
			ST_M3: im_q <= prod_cp;
			ST_M4: im_q <= im_q - prod_cp;
			ST_START: begin
				neg_q <= im_q[CP_W-1];
				mag_q <= {1'b0, HALF_PI_Q40};
			end
			ST_CORDIC: begin
				// left half plane reflects about pi/2
				if (cst.done) begin
					mag_q <= re_q[CP_W-1] ? PI_Q40 - {1'b0, theta} : {1'b0, theta};
				end
			end
			ST_SCALE_HI: acc_q <= prod[CHUNK_W+SCALE_W-1:CHUNK_W];
			default: begin
			end
		endcase
		if (load) begin
			freq_q <= neg_q ? $signed(-dev_mag) : $signed(dev_mag);
		end
	end

	`ASSERT_CLK(a_cordic_nonzero, clk, arst_n, cctl.start |-> (re_q != '0), "cordic on zero real")
	`ASSERT_CLK(a_done_in_wait, clk, arst_n, cst.done |-> (state_q == ST_CORDIC), "stray cordic done")
	`ASSERT_CLK(a_cordic_alive, clk, arst_n, (state_q == ST_CORDIC) |-> (cst.busy || cst.done), "idle")

endmodule

@@ test/fpd_checker.sv @@
// result checker for the phase difference demodulator: predicts freq_dev per sample beat and compares
module fpd_checker import fpd_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_i,
	input  logic signed [SAMPLE_BITS-1:0] in_q,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [OUT_W-1:0]       out_dev,
	output int                            mismatches,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit [63:0] DEV_GAIN    = 64'd2670000;
	localparam int        ROT_STEPS   = 40;
	localparam int        REPORT_MAX  = 10;

	bit [63:0]                     atan_tab [ROT_STEPS];
	bit [63:0]                     half_pi_ang;
	bit [63:0]                     pi_ang;
	logic [OUT_W-1:0]              dev_expected [$];
	logic [OUT_W-1:0]              dev_want;
	logic signed [SAMPLE_BITS-1:0] last_i;
	logic signed [SAMPLE_BITS-1:0] last_q;

	// alternating arctangent series sum(p^(2n+1)/(2n+1)), p scaled by 2^60, q = x^2 for arctan(1/x)
	function automatic longint signed arctan_series(bit [63:0] p, bit [63:0] q);
		longint signed acc;
		bit [63:0]     n;
		bit [63:0]     t;
		acc = 0;
		n = 0;
		while (p != 0) begin
			t = p / (2 * n + 1);
			if (n[0] == 1'b0) acc += longint'(t);
			else acc -= longint'(t);
			if (q == 0) break;
			p = p / q;
			n++;
		end
		return acc;
	endfunction

	function automatic bit [63:0] round_q40(bit [63:0] v);
		return (v + (64'd1 << 19)) >> 20;
	endfunction

	// arctangent table and the pi constants, all in units of 2^-40 rad
	initial begin
		bit [63:0] quarter;
		bit [63:0] q;
		quarter = 64'(arctan_series(64'd1 << 59, 64'd4) +
			arctan_series((64'd1 << 60) / 3, 64'd9));
		atan_tab[0] = round_q40(quarter);
		half_pi_ang = round_q40(2 * quarter);
		pi_ang      = round_q40(4 * quarter);
		for (int k = 1; k < ROT_STEPS; k++) begin
			q = (2 * k < 64) ? (64'd1 << (2 * k)) : 64'd0;
			atan_tab[k] = round_q40(64'(arctan_series(64'd1 << (60 - k), q)));
		end
	end

	// angle of (a, b), a > 0, b >= 0, by vectoring rotations, clamped to [0, pi/2]
	function automatic bit [63:0] vector_angle(bit [63:0] a, bit [63:0] b);
		longint signed x, y, z, dx, dy;
		while ((a > b ? a : b) < (64'd1 << 59)) begin
			a = a << 1;
			b = b << 1;
		end
		x = a;
		y = b;
		z = 0;
		for (int k = 0; k < ROT_STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += longint'(atan_tab[k]);
			end else begin
				x -= dx;
				y += dy;
				z -= longint'(atan_tab[k]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(half_pi_ang)) z = longint'(half_pi_ang);
		return 64'(z);
	endfunction

	// phase step from the old sample to the new one, scaled to a deviation word
	function automatic logic [OUT_W-1:0] phase_step_dev(
		logic signed [SAMPLE_BITS-1:0] new_i, logic signed [SAMPLE_BITS-1:0] new_q,
		logic signed [SAMPLE_BITS-1:0] old_i, logic signed [SAMPLE_BITS-1:0] old_q);
		longint signed re, im;
		bit [63:0]     mag, theta, scaled;
		re = longint'(new_i) * longint'(old_i) + longint'(new_q) * longint'(old_q);
		im = longint'(new_q) * longint'(old_i) - longint'(new_i) * longint'(old_q);
		if (re == 0) begin
			mag = half_pi_ang;
		end else begin
			theta = vector_angle(re < 0 ? -re : re, im < 0 ? -im : im);
			mag = (re > 0) ? theta : pi_ang - theta;
		end
		scaled = (mag * DEV_GAIN) >> 40;
		if (im < 0) scaled = -scaled;
		return scaled[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_expected.delete();
			last_i = '0;
			last_q = '0;
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (dev_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected freq_dev beat: got %0d", $signed(out_dev));
				end else begin
					dev_want = dev_expected.pop_front();
					if (dev_want !== out_dev) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("freq_dev mismatch: expected %0d, got %0d",
								$signed(dev_want), $signed(out_dev));
					end
				end
			end
			if (in_valid && in_ready) begin
				dev_expected.push_back(phase_step_dev(in_i, in_q, last_i, last_q));
				last_i = in_i;
				last_q = in_q;
			end
			outstanding = dev_expected.size();
		end
	end

endmodule

@@ test/tb.sv @@
// testbench top of the phase difference demodulator: clock, reset, sample stimulus and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fpd_pkg::*;

	localparam int SAMPLE_BITS  = 16;
	localparam int ITEMS        = 800;   // random sample beats after the directed part
	localparam int QUIET_ITEMS  = 150;   // closing stretch with no idling on either side
	localparam int PAUSE_AT     = 300;   // sender waits for a fully drained block here
	localparam int HOLD_AT      = 450;   // receiver starts its long hold-off here
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 80;    // a bit over the longest item latency
	localparam int IDLE_LIMIT   = 2000;  // well past the long hold-off plus one item

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   idle_cycles;
	bit   quiet    = 1'b0;  // no idling in the final part of the run
	bit   hold_req = 1'b0;  // set by the stimulus, cleared by the receiver once served

	fpd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples_if ();
	fpd_out_if                             result_if ();

	fm_phase_difference_demod #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.result (result_if)
	);

	// the checker watches both channels and keeps its own running count of mismatches
	fpd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (samples_if.valid),
		.in_ready   (samples_if.ready),
		.in_i       (samples_if.sample_i),
		.in_q       (samples_if.sample_q),
		.out_valid  (result_if.valid),
		.out_ready  (result_if.ready),
		.out_dev    (result_if.freq_dev),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// offer one sample beat from a falling edge and return at the falling edge after it is taken;
	// valid stays high so a following call keeps the channel busy back to back
	task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] si,
		input logic signed [SAMPLE_BITS-1:0] sq);
		samples_if.valid    <= 1'b1;
		samples_if.sample_i <= si;
		samples_if.sample_q <= sq;
		do @(posedge clk); while (!samples_if.ready);
		@(negedge clk);
	endtask

	// drop valid for a number of cycles
	task automatic sender_gap(input int cycles);
		samples_if.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// convert a real to a sample, truncating toward zero, saturating at the rails
	function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(input real v);
		if (v > 32767.0) return 16'sd32767;
		if (v < -32768.0) return -16'sd32768;
		return SAMPLE_BITS'($rtoi(v));
	endfunction

	// one of the corner values of a sample
	function automatic logic signed [SAMPLE_BITS-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0:       return -16'sd32768;
			1:       return 16'sd32767;
			2:       return 16'sd0;
			3:       return -16'sd1;
			default: return 16'sd1;
		endcase
	endfunction

	// receiver: short random stalls, one long hold-off on request, none in the quiet part
	initial begin
		result_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				// long hold-off so the output register and the sequencer both fill up
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				result_if.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			@(negedge clk);
		end
	end

	// watchdog: too long without any beat on either channel ends the run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((samples_if.valid && samples_if.ready) ||
			(result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int                            n;
		int                            kind;
		real                           phase;
		real                           step;
		real                           amp;
		logic signed [SAMPLE_BITS-1:0] si;
		logic signed [SAMPLE_BITS-1:0] sq;
		logic signed [SAMPLE_BITS-1:0] last_si;
		logic signed [SAMPLE_BITS-1:0] last_sq;

		samples_if.valid    = 1'b0;
		samples_if.sample_i = '0;
		samples_if.sample_q = '0;
		arst_n = 1'b0;
		phase = 0.0;
		step = 0.1;
		amp = 20000.0;
		last_si = '0;
		last_sq = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: the stored sample starts at zero, so the first two give a zero product
		offer_sample(16'sd0, 16'sd0);
		offer_sample(16'sd32767, 16'sd0);
		offer_sample(16'sd32767, 16'sd0);          // same sample twice: zero step
		offer_sample(-16'sd32768, 16'sd0);         // negative real, zero imag: plus pi
		offer_sample(16'sd0, 16'sd32767);          // zero real, negative imag: minus pi/2
		offer_sample(16'sd0, -16'sd32768);         // opposite phasors again
		offer_sample(-16'sd32768, -16'sd32768);    // largest magnitude products
		offer_sample(16'sd32767, 16'sd32767);
		offer_sample(-16'sd32768, 16'sd32767);
		offer_sample(16'sd32767, -16'sd32768);
		offer_sample(16'sd1, 16'sd0);
		offer_sample(16'sd0, 16'sd1);              // zero real, positive imag
		offer_sample(-16'sd1, 16'sd0);
		offer_sample(16'sd0, -16'sd1);
		offer_sample(16'sd1, 16'sd1);              // negative real, small positive imag
		offer_sample(16'sd1, -16'sd1);
		offer_sample(16'sd32767, 16'sd1);
		offer_sample(16'sd32767, 16'sd2);          // tiny positive step
		offer_sample(16'sd32767, 16'sd1);          // tiny negative step
		offer_sample(-16'sd1, -16'sd1);
		offer_sample(16'sd0, 16'sd0);              // zero new sample
		offer_sample(-16'sd32768, -16'sd32768);    // zero old sample
		last_si = -16'sd32768;
		last_sq = -16'sd32768;

		// random part: mostly an fm-like rotating phasor, mixed with noise and corner values
		for (n = 0; n < ITEMS; n++) begin
			if (n == ITEMS - QUIET_ITEMS) quiet = 1'b1;
			if (n == PAUSE_AT) begin
				// hold the sender until every predicted deviation has been seen
				sender_gap(1);
				while (outstanding != 0) @(negedge clk);
			end
			if (n == HOLD_AT) hold_req = 1'b1;
			if (n % 60 == 0) begin
				// new carrier: small or clipping amplitudes now and then, steps across (-pi, pi)
				if ($urandom_range(0, 3) == 0) amp = real'($urandom_range(1, 100));
				else amp = real'($urandom_range(1000, 46000));
				step = real'(int'($urandom_range(0, 2000)) - 1000) / 1000.0 * 3.14159265;
			end
			kind = $urandom_range(0, 9);
			case (kind)
				5: begin
					si = SAMPLE_BITS'($urandom);
					sq = SAMPLE_BITS'($urandom);
				end
				6: begin
					si = SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
					sq = SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
				end
				7: begin
					si = pick_extreme();
					sq = pick_extreme();
				end
				8: begin
					// repeated or negated sample: zero step or half a turn
					if ($urandom_range(0, 1) == 0) begin
						si = last_si;
						sq = last_sq;
					end else begin
						si = -last_si;
						sq = -last_sq;
					end
				end
				9: begin
					// quarter turn gives a zero real part, all-zero gives a zero product
					if ($urandom_range(0, 1) == 0) begin
						si = -last_sq;
						sq = last_si;
					end else begin
						si = '0;
						sq = '0;
					end
				end
				default: begin
					phase = phase + step;
					if (phase > 3.14159265) phase = phase - 6.2831853;
					if (phase < -3.14159265) phase = phase + 6.2831853;
					si = clip_sample(amp * $cos(phase));
					sq = clip_sample(amp * $sin(phase));
				end
			endcase
			if (!quiet && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 5));
			offer_sample(si, sq);
			last_si = si;
			last_sq = sq;
		end

		// drain: wait for the last deviation, then a little longer for stray beats
		sender_gap(1);
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
